>>> design/ovlm_pkg.sv
// Shared constants for the ordered value list with min/max tracking.
// Holds field widths, operation kinds, status codes and cell commands.
// No dependencies.
`default_nettype none

package ovlm_pkg;

   // Default sizing of the list.
   localparam int CAPACITY_DEFAULT   = 64;
   localparam int VALUE_BITS_DEFAULT = 32;

   // Fixed field widths of the stream beats.
   localparam int KIND_W     = 3;
   localparam int DATA_W     = 32;
   localparam int POS_W      = 6;
   localparam int COUNT_W    = 7;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 120;

   // Operation kinds carried on req_tuser.
   localparam logic [KIND_W-1:0] KIND_APPEND    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ORDERED   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INSERT_AT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DELETE_AT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ      = 3'd4;

   // Status codes of a result beat.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // Commands broadcast to every cell of the row.
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_HOLD   = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

endpackage

`default_nettype wire

>>> design/ovlm_cell.sv
// One cell of the list row: holds one entry and one stage of the min/max sweep.
// Depends on ovlm_pkg for the command codes.
`default_nettype none

module ovlm_cell #(
   parameter int CAPACITY   = ovlm_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_BITS = ovlm_pkg::VALUE_BITS_DEFAULT,
   parameter int INDEX      = 0,
   localparam int CNT_W     = $clog2(CAPACITY + 1),
   localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire [ovlm_pkg::OP_W-1:0]     cmd_op,
   input  wire [CNT_W-1:0]              cmd_at,
   input  wire [CNT_W-1:0]              cmd_count,
   input  wire signed [VALUE_BITS-1:0]  cmd_value,
   input  wire                          order_descending,
   input  wire signed [VALUE_BITS-1:0]  left_entry,
   input  wire signed [VALUE_BITS-1:0]  right_entry,
   input  wire                          left_found,
   input  wire signed [VALUE_BITS-1:0]  left_min,
   input  wire [IDX_W-1:0]              left_min_at,
   input  wire signed [VALUE_BITS-1:0]  left_max,
   input  wire [IDX_W-1:0]              left_max_at,
   output logic signed [VALUE_BITS-1:0] entry,
   output logic                         not_before,
   output logic                         found,
   output logic signed [VALUE_BITS-1:0] min_value,
   output logic [IDX_W-1:0]             min_at,
   output logic signed [VALUE_BITS-1:0] max_value,
   output logic [IDX_W-1:0]             max_at
);

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);
   localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(INDEX);

   logic signed [VALUE_BITS-1:0] entry_ff, entry_in;
   logic                         found_ff, found_in;
   logic signed [VALUE_BITS-1:0] min_ff, min_in, max_ff, max_in;
   logic [IDX_W-1:0]             min_at_ff, min_at_in, max_at_ff, max_at_in;
   logic                         occupied;
   logic                         sorts_ahead;

   assign occupied = (MY_INDEX < cmd_count);

   // Ordered insert goes before the first occupied entry that does not sort ahead.
   assign sorts_ahead = order_descending ? (cmd_value < entry_ff) : (entry_ff < cmd_value);
   assign not_before  = occupied && !sorts_ahead;

   // Entry update: insert shifts later entries up, delete shifts them down.
   always_comb begin
      entry_in = entry_ff;
      case (cmd_op)
         ovlm_pkg::OP_INSERT: begin
            if (MY_INDEX == cmd_at) begin
               entry_in = cmd_value;
            end else if (MY_INDEX > cmd_at) begin
               entry_in = left_entry;
            end
         end
         ovlm_pkg::OP_DELETE: begin
            if (MY_INDEX >= cmd_at) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // One stage of the sweep: fold this entry into the running min/max from the left.
   always_comb begin
      found_in  = left_found;
      min_in    = left_min;
      min_at_in = left_min_at;
      max_in    = left_max;
      max_at_in = left_max_at;
      if (occupied) begin
         found_in = 1'b1;
         if (!left_found) begin
            min_in    = entry_ff;
            min_at_in = MY_IDX;
            max_in    = entry_ff;
            max_at_in = MY_IDX;
         end else begin
            if (entry_ff < left_min) begin
               min_in    = entry_ff;
               min_at_in = MY_IDX;
            end
            if (left_max < entry_ff) begin
               max_in    = entry_ff;
               max_at_in = MY_IDX;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff  <= entry_in;
      min_ff    <= min_in;
      min_at_ff <= min_at_in;
      max_ff    <= max_in;
      max_at_ff <= max_at_in;
   end

   assign entry     = entry_ff;
   assign found     = found_ff;
   assign min_value = min_ff;
   assign min_at    = min_at_ff;
   assign max_value = max_ff;
   assign max_at    = max_at_ff;

endmodule

`default_nettype wire

>>> design/ordered_value_list_minmax_core.sv
// Top level of the ordered value list: sequencer, row of cells and result register.
// Depends on ovlm_pkg and ovlm_cell.
//
// Usage:
//   Request beats enter on req_*: req_tuser carries the operation kind, req_tdata
//   the value and the entry index. Each request gives exactly one result beat on
//   rsp_*, with the read value, entry count, minimum and maximum with their lowest
//   indices, and a status code.
//   A request is taken only while the block is idle. It then goes through the
//   ordered-insert compare, the shift of the entries of the cell row, and the
//   min/max sweep, which runs through the row one cell per cycle; the result
//   register is loaded when the sweep is done. A new request is not taken until
//   the result of the last one has gone into the result register.
//   The result register holds a finished beat while the receiver stalls; the next
//   request is still taken and worked on, and its result waits until the held beat
//   is gone.
//   Reset empties the list, clears the result valid flag and sets ascending order.
//   The user writes order_descending (csr_wen/csr_wdata) only while idle; not enforced.
`default_nettype none

module ordered_value_list_minmax_core #(
   parameter int CAPACITY   = ovlm_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_BITS = ovlm_pkg::VALUE_BITS_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   // Configuration write.
   input  wire                               csr_wen,
   input  wire                               csr_wdata,   // order_descending
   // Request channel.
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire [ovlm_pkg::REQ_DATA_W-1:0]    req_tdata,   // value[31:0], position[37:32]
   input  wire [ovlm_pkg::KIND_W-1:0]        req_tuser,   // kind[2:0]
   // Result channel.
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [ovlm_pkg::RSP_DATA_W-1:0]   rsp_tdata    // read_value[31:0],
                                                          // entry_count[38:32],
                                                          // min_value[70:39],
                                                          // min_position[76:71],
                                                          // max_value[108:77],
                                                          // max_position[114:109],
                                                          // status[116:115]
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W = (CNT_W > ovlm_pkg::POS_W) ? CNT_W : ovlm_pkg::POS_W;
   localparam int PAD_W = ovlm_pkg::RSP_DATA_W - 117;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] SWEEP_LAST = CNT_W'(CAPACITY - 1);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FIND  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_SWEEP = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]                      state_ff, state_in;
   logic [CNT_W-1:0]                sweep_ff, sweep_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic                            desc_ff;
   logic [ovlm_pkg::KIND_W-1:0]     kind_ff;
   logic signed [VALUE_BITS-1:0]    value_ff;
   logic [ovlm_pkg::POS_W-1:0]      pos_ff;
   logic [CAPACITY-1:0]             nb_ff;
   logic signed [VALUE_BITS-1:0]    rd_ff, rd_in;
   logic [ovlm_pkg::STATUS_W-1:0]   status_ff, status_in;

   logic                            rsp_valid_ff;
   logic [ovlm_pkg::DATA_W-1:0]     out_rd_ff, out_min_ff, out_max_ff;
   logic [ovlm_pkg::COUNT_W-1:0]    out_count_ff;
   logic [ovlm_pkg::POS_W-1:0]      out_min_at_ff, out_max_at_ff;
   logic [ovlm_pkg::STATUS_W-1:0]   out_status_ff;

   logic                            req_take;
   logic                            rsp_free;
   logic signed [ovlm_pkg::DATA_W-1:0] req_value;

   logic [ovlm_pkg::OP_W-1:0]       cmd_op;
   logic [CNT_W-1:0]                cmd_at;
   logic [CNT_W-1:0]                ordered_at;
   logic [CMP_W-1:0]                pos_c, count_c;
   logic                            list_full;
   logic                            pos_in_range;

   // Cell row wiring, each element read at its own fixed place.
   logic signed [VALUE_BITS-1:0]    cell_entry [CAPACITY];
   logic [CAPACITY-1:0]             cell_nb;
   logic [CAPACITY-1:0]             cell_found;
   logic signed [VALUE_BITS-1:0]    cell_min [CAPACITY];
   logic signed [VALUE_BITS-1:0]    cell_max [CAPACITY];
   logic [IDX_W-1:0]                cell_min_at [CAPACITY];
   logic [IDX_W-1:0]                cell_max_at [CAPACITY];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_value  = req_tdata[31:0];

   assign pos_c        = CMP_W'(pos_ff);
   assign count_c      = CMP_W'(count_ff);
   assign list_full    = (count_ff >= FULL_COUNT);
   assign pos_in_range = (pos_c < count_c);

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         desc_ff <= 1'b0;
      end else if (csr_wen) begin
         desc_ff <= csr_wdata;
      end
   end

   // Request capture and compare flags.
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff  <= req_tuser;
         value_ff <= VALUE_BITS'(req_value);
         pos_ff   <= req_tdata[37:32];
      end
      if (state_ff == ST_FIND) begin
         nb_ff <= cell_nb;
      end
   end

   // First occupied entry that the new value goes before.
   always_comb begin
      ordered_at = count_ff;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (nb_ff[i]) begin
            ordered_at = CNT_W'(i);
         end
      end
   end

   // Operation decode, applied to the cell row in the shift cycle.
   always_comb begin
      cmd_op    = ovlm_pkg::OP_HOLD;
      cmd_at    = count_ff;
      count_in  = count_ff;
      status_in = ovlm_pkg::STATUS_OK;
      rd_in     = '0;
      case (kind_ff)
         ovlm_pkg::KIND_APPEND, ovlm_pkg::KIND_ORDERED, ovlm_pkg::KIND_INSERT_AT: begin
            if (list_full) begin
               status_in = ovlm_pkg::STATUS_FULL;
            end else begin
               cmd_op   = ovlm_pkg::OP_INSERT;
               count_in = count_ff + 1'b1;
               if (kind_ff == ovlm_pkg::KIND_ORDERED) begin
                  cmd_at = ordered_at;
               end else if (kind_ff == ovlm_pkg::KIND_INSERT_AT && pos_in_range) begin
                  cmd_at = CNT_W'(pos_ff);
               end
            end
         end
         ovlm_pkg::KIND_DELETE_AT: begin
            if (!pos_in_range) begin
               status_in = ovlm_pkg::STATUS_RANGE;
            end else begin
               cmd_op   = ovlm_pkg::OP_DELETE;
               cmd_at   = CNT_W'(pos_ff);
               count_in = count_ff - 1'b1;
            end
         end
         ovlm_pkg::KIND_READ: begin
            if (!pos_in_range) begin
               status_in = ovlm_pkg::STATUS_RANGE;
            end else begin
               for (int i = 0; i < CAPACITY; i++) begin
                  if (pos_c == CMP_W'(i)) begin
                     rd_in = cell_entry[i];
                  end
               end
            end
         end
         default: begin
            status_in = ovlm_pkg::STATUS_OK;
         end
      endcase
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_SWEEP;
            sweep_in = SWEEP_LAST;
         end
         ST_SWEEP: begin
            if (sweep_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               sweep_in = sweep_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sweep_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         if (state_ff == ST_EXEC) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         rd_ff     <= rd_in;
         status_ff <= status_in;
      end
   end

   // Row of cells, each taking its neighbors' entries and the sweep from the left.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VALUE_BITS-1:0] left_entry, right_entry, left_min, left_max;
      logic [IDX_W-1:0]             left_min_at, left_max_at;
      logic                         left_found;

      if (g == 0) begin : g_first
         assign left_entry  = cell_entry[g];
         assign left_found  = 1'b0;
         assign left_min    = '0;
         assign left_max    = '0;
         assign left_min_at = '0;
         assign left_max_at = '0;
      end else begin : g_next
         assign left_entry  = cell_entry[g-1];
         assign left_found  = cell_found[g-1];
         assign left_min    = cell_min[g-1];
         assign left_max    = cell_max[g-1];
         assign left_min_at = cell_min_at[g-1];
         assign left_max_at = cell_max_at[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_entry = cell_entry[g];
      end else begin : g_inner
         assign right_entry = cell_entry[g+1];
      end

      ovlm_cell #(
         .CAPACITY   (CAPACITY),
         .VALUE_BITS (VALUE_BITS),
         .INDEX      (g)
      ) u_cell (
         .clock            (clock),
         .reset            (reset),
         .cmd_op           ((state_ff == ST_EXEC) ? cmd_op : ovlm_pkg::OP_HOLD),
         .cmd_at           (cmd_at),
         .cmd_count        (count_ff),
         .cmd_value        (value_ff),
         .order_descending (desc_ff),
         .left_entry       (left_entry),
         .right_entry      (right_entry),
         .left_found       (left_found),
         .left_min         (left_min),
         .left_min_at      (left_min_at),
         .left_max         (left_max),
         .left_max_at      (left_max_at),
         .entry            (cell_entry[g]),
         .not_before       (cell_nb[g]),
         .found            (cell_found[g]),
         .min_value        (cell_min[g]),
         .min_at           (cell_min_at[g]),
         .max_value        (cell_max[g]),
         .max_at           (cell_max_at[g])
      );
   end

   // Result register, loaded once the sweep has reached the last cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && rsp_free) begin
         out_rd_ff     <= ovlm_pkg::DATA_W'(rd_ff);
         out_count_ff  <= ovlm_pkg::COUNT_W'(count_ff);
         out_status_ff <= status_ff;
         if (cell_found[CAPACITY-1]) begin
            out_min_ff    <= ovlm_pkg::DATA_W'(cell_min[CAPACITY-1]);
            out_min_at_ff <= ovlm_pkg::POS_W'(cell_min_at[CAPACITY-1]);
            out_max_ff    <= ovlm_pkg::DATA_W'(cell_max[CAPACITY-1]);
            out_max_at_ff <= ovlm_pkg::POS_W'(cell_max_at[CAPACITY-1]);
         end else begin
            out_min_ff    <= '0;
            out_min_at_ff <= '0;
            out_max_ff    <= '0;
            out_max_at_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_status_ff, out_max_at_ff, out_max_ff,
                        out_min_at_ff, out_min_ff, out_count_ff, out_rd_ff};

endmodule

`default_nettype wire
